[hdl/alc_pkg.sv]
// Shared types, constants and coefficient tables for the ambient light lux calculator.
`timescale 1ns / 1ps

package alc_pkg;

    localparam int CNT_W       = 16;
    localparam int LUX_W       = 16;
    localparam int CH_SCALE    = 10;
    localparam int RATIO_SCALE = 9;
    localparam int RATIO_SHIFT = RATIO_SCALE + 1;
    localparam int LUX_SHIFT   = 14;
    localparam int SEGMENTS    = 8;
    localparam int SEG_W       = $clog2(SEGMENTS);

    localparam int SCALE_W = 19;
    localparam int PRE_W   = CNT_W + SCALE_W;
    localparam int CH_W    = PRE_W - CH_SCALE;
    localparam int BRK_W   = 10;
    localparam int THR_W   = BRK_W + 1;
    localparam int CMP_W   = CH_W + THR_W;
    localparam int COEF_W  = 10;
    localparam int TERM_W  = CH_W + COEF_W;
    localparam int SUM_W   = TERM_W + 1;
    localparam int LUXW_W  = SUM_W - LUX_SHIFT;

    localparam logic [CNT_W-1:0] CHSCALE_TINT0 = 16'h7517;
    localparam logic [CNT_W-1:0] CHSCALE_TINT1 = 16'h0FE7;

    localparam int MIDQ_DEPTH = 8;
    localparam int OUTQ_DEPTH = 8;
    localparam int QPTR_W     = $clog2(MIDQ_DEPTH);
    localparam int QCNT_W     = $clog2(MIDQ_DEPTH + 1);
    localparam int OPTR_W     = $clog2(OUTQ_DEPTH);
    localparam int OCNT_W     = $clog2(OUTQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_HIGH   = 2'd0,
        REG_INTEGRATION = 2'd1,
        REG_PACKAGE     = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TINT_13MS    = 2'd0,
        TINT_101MS   = 2'd1,
        TINT_NOMINAL = 2'd2
    } tint_t;

    localparam logic [BRK_W-1:0] SEG_K [2][SEGMENTS] = '{
        '{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A},
        '{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A, 10'h29A}
    };

    localparam logic [COEF_W-1:0] SEG_B [2][SEGMENTS] = '{
        '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };

    localparam logic [COEF_W-1:0] SEG_M [2][SEGMENTS] = '{
        '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000},
        '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000}
    };

    typedef struct packed {
        logic [CH_W-1:0]  c0;
        logic [CH_W-1:0]  c1;
        logic [SEG_W-1:0] seg;
        logic             pkg;
    } seg_item_t;

    typedef struct packed {
        logic      push;
        seg_item_t item;
    } midq_wr_t;

    typedef struct packed {
        logic      valid;
        seg_item_t item;
    } midq_rd_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             sat;
    } lux_res_t;

endpackage

[hdl/alc_front.sv]
// Front end: configuration registers, channel scaling and segment selection.
`timescale 1ns / 1ps

module alc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [alc_pkg::CNT_W-1:0]      broadband_count,
    input  logic [alc_pkg::CNT_W-1:0]      infrared_count,
    input  logic                           cfg_valid,
    input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           midq_pop,
    output alc_pkg::midq_wr_t              midq_wr
);
    import alc_pkg::*;

    logic              gain_high_reg;
    logic [1:0]        integration_select_reg;
    logic              package_cs_reg;

    logic              accept;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    logic              v1_reg;
    logic [CNT_W-1:0]  ch0_1_reg;
    logic [CNT_W-1:0]  ch1_1_reg;

    logic [SCALE_W-1:0] scale_base;
    logic [SCALE_W-1:0] scale_next;
    logic [PRE_W-1:0]   pre0;
    logic [PRE_W-1:0]   pre1;

    logic              v2_reg;
    logic [CH_W-1:0]   c0_2_reg;
    logic [CH_W-1:0]   c1_2_reg;

    logic              v3_reg;
    logic [CH_W-1:0]   c0_3_reg;
    logic [CH_W-1:0]   c1_3_reg;
    logic              zero_3_reg;
    logic [CMP_W-1:0]  thr_prod_next [SEGMENTS-1];
    logic [CMP_W-1:0]  thr_prod_reg [SEGMENTS-1];

    logic [CMP_W-1:0]  ratio_lhs;
    logic [SEG_W-1:0]  seg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_high_reg          <= 1'b0;
            integration_select_reg <= TINT_NOMINAL;
            package_cs_reg         <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_HIGH:   gain_high_reg          <= cfg_data[0];
                REG_INTEGRATION: integration_select_reg <= cfg_data[1:0];
                REG_PACKAGE:     package_cs_reg         <= cfg_data[0];
                default:         gain_high_reg          <= gain_high_reg;
            endcase
        end
    end

    // Credits cover every item from acceptance until the back end takes it from the queue.
    assign full   = (cnt_reg == QCNT_W'(MIDQ_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !midq_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && midq_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (integration_select_reg)
            TINT_13MS:  scale_base = SCALE_W'(CHSCALE_TINT0);
            TINT_101MS: scale_base = SCALE_W'(CHSCALE_TINT1);
            default:    scale_base = SCALE_W'(1 << CH_SCALE);
        endcase
        scale_next = gain_high_reg ? scale_base : (scale_base << 4);
        pre0 = PRE_W'(ch0_1_reg) * PRE_W'(scale_next);
        pre1 = PRE_W'(ch1_1_reg) * PRE_W'(scale_next);
    end

    // A rounded ratio at or below a break point K means c1 * 1024 < (2K + 1) * c0.
    always_comb
    begin
        for (int i = 0; i < SEGMENTS - 1; i++)
        begin
            thr_prod_next[i] = CMP_W'(c0_2_reg) *
                               CMP_W'({SEG_K[package_cs_reg][i], 1'b1});
        end
    end

    always_comb
    begin
        ratio_lhs = CMP_W'({c1_3_reg, {RATIO_SHIFT{1'b0}}});
        seg_next  = SEG_W'(SEGMENTS - 1);
        for (int i = SEGMENTS - 2; i >= 0; i--)
        begin
            if (ratio_lhs < thr_prod_reg[i])
            begin
                seg_next = SEG_W'(i);
            end
        end
        if (zero_3_reg)
        begin
            seg_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch0_1_reg <= broadband_count;
            ch1_1_reg <= infrared_count;
        end
        c0_2_reg     <= pre0[PRE_W-1:CH_SCALE];
        c1_2_reg     <= pre1[PRE_W-1:CH_SCALE];
        c0_3_reg     <= c0_2_reg;
        c1_3_reg     <= c1_2_reg;
        zero_3_reg   <= (c0_2_reg == '0);
        thr_prod_reg <= thr_prod_next;
    end

    assign midq_wr.push     = v3_reg;
    assign midq_wr.item.c0  = c0_3_reg;
    assign midq_wr.item.c1  = c1_3_reg;
    assign midq_wr.item.seg = seg_next;
    assign midq_wr.item.pkg = package_cs_reg;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(MIDQ_DEPTH))
        else $error("front credit count exceeds the queue depth");

    a_credit_covers_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= QCNT_W'($countones({v1_reg, v2_reg, v3_reg})))
        else $error("front pipeline holds more items than credits");

endmodule

[hdl/alc_midq.sv]
// Queue that decouples the segment selection front end from the lux back end.
`timescale 1ns / 1ps

module alc_midq (
    input  logic              clk,
    input  logic              rst_n,
    input  alc_pkg::midq_wr_t wr,
    input  logic              pop,
    output alc_pkg::midq_rd_t rd
);
    import alc_pkg::*;

    seg_item_t         mem_reg [MIDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.item;
        end
    end

    assign rd.valid = (count_reg != '0);
    assign rd.item  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> count_reg < QCNT_W'(MIDQ_DEPTH))
        else $error("write into a full middle queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("read from an empty middle queue");

endmodule

[hdl/alc_back.sv]
// Back end: coefficient lookup, weighted difference, rounding, saturation and result queue.
`timescale 1ns / 1ps

module alc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  alc_pkg::midq_rd_t         head,
    output logic                      take,
    input  logic                      pop,
    output logic                      empty,
    output logic [alc_pkg::LUX_W-1:0] lux_value,
    output logic                      lux_saturated
);
    import alc_pkg::*;

    logic [OCNT_W-1:0]  cnt_reg;
    logic [OCNT_W-1:0]  cnt_next;
    logic               deliver;

    logic               v1_reg;
    logic [CH_W-1:0]    c0_1_reg;
    logic [CH_W-1:0]    c1_1_reg;
    logic [COEF_W-1:0]  b_1_reg;
    logic [COEF_W-1:0]  m_1_reg;

    logic               v2_reg;
    logic [TERM_W-1:0]  pos_2_reg;
    logic [TERM_W-1:0]  neg_2_reg;

    logic [TERM_W-1:0]  diff;
    logic [SUM_W-1:0]   rounded;
    logic [LUXW_W-1:0]  lux_wide;
    lux_res_t           res_next;

    lux_res_t           oq_reg [OUTQ_DEPTH];
    logic [OPTR_W-1:0]  oq_wr_ptr_reg;
    logic [OPTR_W-1:0]  oq_rd_ptr_reg;
    logic [OCNT_W-1:0]  oq_cnt_reg;
    logic [OCNT_W-1:0]  oq_cnt_next;

    // Credits reserve a result queue slot for every item in the back pipeline.
    assign take    = head.valid && (cnt_reg < OCNT_W'(OUTQ_DEPTH));
    assign empty   = (oq_cnt_reg == '0);
    assign deliver = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take && !deliver)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!take && deliver)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        oq_cnt_next = oq_cnt_reg;
        if (v2_reg && !deliver)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (!v2_reg && deliver)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    // A negative difference clamps to zero before rounding.
    always_comb
    begin
        diff     = (pos_2_reg > neg_2_reg) ? (pos_2_reg - neg_2_reg) : '0;
        rounded  = SUM_W'(diff) + SUM_W'(1 << (LUX_SHIFT - 1));
        lux_wide = rounded[SUM_W-1:LUX_SHIFT];
        res_next.sat = (lux_wide[LUXW_W-1:LUX_W] != '0);
        res_next.lux = res_next.sat ? '1 : lux_wide[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            v1_reg     <= take;
            v2_reg     <= v1_reg;
            oq_cnt_reg <= oq_cnt_next;
            if (v2_reg)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (deliver)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            c0_1_reg <= head.item.c0;
            c1_1_reg <= head.item.c1;
            b_1_reg  <= SEG_B[head.item.pkg][head.item.seg];
            m_1_reg  <= SEG_M[head.item.pkg][head.item.seg];
        end
        pos_2_reg <= TERM_W'(c0_1_reg) * TERM_W'(b_1_reg);
        neg_2_reg <= TERM_W'(c1_1_reg) * TERM_W'(m_1_reg);
        if (v2_reg)
        begin
            oq_reg[oq_wr_ptr_reg] <= res_next;
        end
    end

    assign lux_value     = oq_reg[oq_rd_ptr_reg].lux;
    assign lux_saturated = oq_reg[oq_rd_ptr_reg].sat;

    a_credit_exact: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == oq_cnt_reg + OCNT_W'($countones({v1_reg, v2_reg})))
        else $error("back credit count does not match items held");

endmodule

[hdl/ambient_light_lux_calculator.sv]
// Top level of the two-channel ambient light lux calculator.
`timescale 1ns / 1ps

// Takes one broadband/infrared count pair per beat and returns one lux result per beat, in
// order. A new pair is accepted every cycle while results keep being popped. On its way to
// the output side a pair passes the input register, one register each after the scaling
// multipliers and the parallel break-point multipliers, the eight-entry queue between the
// segment selection front end and the lux back end, one register each after the coefficient
// lookup and the coefficient multipliers, and the result queue. Configuration writes are
// always accepted and take effect for pairs accepted afterwards; they are meant to be
// written while the block is idle.

module ambient_light_lux_calculator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [alc_pkg::CNT_W-1:0]      broadband_count,
    input  logic [alc_pkg::CNT_W-1:0]      infrared_count,
    output logic                           empty,
    input  logic                           pop,
    output logic [alc_pkg::LUX_W-1:0]      lux_value,
    output logic                           lux_saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import alc_pkg::*;

    midq_wr_t midq_wr;
    midq_rd_t midq_rd;
    logic     midq_pop;

    assign cfg_ready = 1'b1;

    alc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .midq_pop        (midq_pop),
        .midq_wr         (midq_wr)
    );

    alc_midq u_midq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (midq_wr),
        .pop   (midq_pop),
        .rd    (midq_rd)
    );

    alc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (midq_rd),
        .take          (midq_pop),
        .pop           (pop),
        .empty         (empty),
        .lux_value     (lux_value),
        .lux_saturated (lux_saturated)
    );

endmodule
